/* hw/rtl/atd_pkg.sv */
package atd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int MAG_W    = 7;
    localparam int ACCUM_W  = 10;
    localparam int THRESH_W = 7;
    localparam int CALIB_W  = 3;
    localparam int AXES     = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd10;
    localparam logic [MAG_W-1:0]    MAG_MAX      = 7'h7F;
    localparam logic [CALIB_W-1:0]  CALIB_ITEMS  = 3'd3;
    localparam logic [CALIB_W-1:0]  CALIB_DONE   = 3'd4;

    // floor(a / 3) for a < 1024 as (a * 683) >> 11
    localparam logic [10:0] DIV3_RECIP = 11'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef enum logic [1:0] {
        PH_CALIB  = 2'd0,
        PH_ORIGIN = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_STOP  = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_FRONT = 3'd4,
        DIR_BACK  = 3'd5
    } dir_t;

    // x in the lowest bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] z_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic [SAMPLE_W-1:0] x_sample;
    } item_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } dev_t;

    // phase in the lowest bits, padded to 32
    typedef struct packed {
        logic [2:0]       pad;
        dir_t             direction;
        logic             z_negative;
        logic [MAG_W-1:0] z_magnitude;
        logic             y_negative;
        logic [MAG_W-1:0] y_magnitude;
        logic             x_negative;
        logic [MAG_W-1:0] x_magnitude;
        phase_t           phase;
    } result_t;

    function automatic logic [SAMPLE_W-1:0] div3(input logic [ACCUM_W-1:0] a);
        logic [20:0] p;
        p = a * DIV3_RECIP;
        return p[DIV3_SHIFT +: SAMPLE_W];
    endfunction

    function automatic dev_t deviation(input logic [SAMPLE_W-1:0] s,
                                       input logic [SAMPLE_W-1:0] o);
        dev_t                d;
        logic [SAMPLE_W-1:0] diff;
        d.neg = (s <= o);
        diff  = d.neg ? (o - s) : (s - o);
        d.mag = (diff > {1'b0, MAG_MAX}) ? MAG_MAX : diff[MAG_W-1:0];
        return d;
    endfunction

    function automatic dir_t dir_update(input dir_t cur, input dev_t d,
                                        input logic [THRESH_W-1:0] thr,
                                        input dir_t pos_code, input dir_t neg_code);
        dir_t r;
        if (!d.neg && d.mag != '0)
        begin
            r = (d.mag > thr) ? pos_code : cur;
        end
        else if (d.neg)
        begin
            r = (d.mag > thr) ? neg_code : DIR_STOP;
        end
        else
        begin
            r = DIR_STOP;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/accel_tilt_direction_detector_top.sv */
// Path: an input transfer reaches m_tdata through the input register, then the result
//   register; a stalled output holds it back. Throughput: one sample triple per cycle
//   unless m_tready stalls, set by the single-pass logic between the two registers.
// Reset (rst_n low, asynchronous): calibration restarts, origins clear, direction NONE,
//   threshold 10, both stream sides empty.
module accel_tilt_direction_detector_top
    import atd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_sample, y_sample, z_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // x_magnitude, x_negative, y_magnitude, y_negative,
                                   // z_magnitude, z_negative, direction, zero pad
    output logic [1:0]  m_tuser,   // phase
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // tilt_threshold
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                item_valid;
    logic                item_ready;
    item_t               item;
    result_t             result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    atd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (item_t'(s_tdata)),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    atd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (thresh_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = {5'b00000, result.direction,
                      result.z_negative, result.z_magnitude,
                      result.y_negative, result.y_magnitude,
                      result.x_negative, result.x_magnitude};
    assign m_tuser = result.phase;

endmodule

/* hw/rtl/atd_in_stage.sv */
module atd_in_stage
    import atd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    output logic  item_valid,
    input  logic  item_ready,
    output item_t item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_tready = !vld_reg || item_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready)
        begin
            vld_next = 1'b1;
        end
        else if (item_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/atd_core.sv */
module atd_core
    import atd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [THRESH_W-1:0] threshold,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output result_t             result
);

    logic [CALIB_W-1:0]  calib_cnt_reg;
    logic [CALIB_W-1:0]  calib_cnt_next;
    logic [ACCUM_W-1:0]  origin_reg [AXES];
    logic [ACCUM_W-1:0]  origin_next [AXES];
    dir_t                dir_reg;
    dir_t                dir_next;
    logic                out_vld_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                advance;
    phase_t              phase;
    logic [SAMPLE_W-1:0] smp [AXES];
    dev_t                dev [AXES];
    dir_t                dir_x;

    assign item_ready = !out_vld_reg || m_tready;
    assign advance    = item_valid && item_ready;

    assign smp[0] = item.x_sample;
    assign smp[1] = item.y_sample;
    assign smp[2] = item.z_sample;

    always_comb
    begin
        if (calib_cnt_reg < CALIB_ITEMS)
        begin
            phase = PH_CALIB;
        end
        else if (calib_cnt_reg == CALIB_ITEMS)
        begin
            phase = PH_ORIGIN;
        end
        else
        begin
            phase = PH_RUN;
        end

        calib_cnt_next = (calib_cnt_reg < CALIB_DONE) ? calib_cnt_reg + 3'd1 : calib_cnt_reg;

        for (int i = 0; i < AXES; i++)
        begin
            dev[i]         = '0;
            origin_next[i] = origin_reg[i];
            case (phase)
                PH_CALIB:  origin_next[i] = origin_reg[i] + {2'b00, smp[i]};
                PH_ORIGIN: origin_next[i] = {2'b00, div3(origin_reg[i])};
                PH_RUN:    dev[i] = deviation(smp[i], origin_reg[i][SAMPLE_W-1:0]);
                default:   origin_next[i] = origin_reg[i];
            endcase
        end

        // y overrides x, except a small positive y, which keeps the x result
        dir_x    = dir_update(dir_reg, dev[0], threshold, DIR_LEFT, DIR_RIGHT);
        dir_next = dir_update(dir_x, dev[1], threshold, DIR_FRONT, DIR_BACK);

        res_next.pad         = '0;
        res_next.phase       = phase;
        res_next.x_magnitude = dev[0].mag;
        res_next.x_negative  = dev[0].neg;
        res_next.y_magnitude = dev[1].mag;
        res_next.y_negative  = dev[1].neg;
        res_next.z_magnitude = dev[2].mag;
        res_next.z_negative  = dev[2].neg;
        res_next.direction   = dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_cnt_reg <= '0;
            dir_reg       <= DIR_NONE;
            out_vld_reg   <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                origin_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                calib_cnt_reg <= calib_cnt_next;
                dir_reg       <= dir_next;
                out_vld_reg   <= 1'b1;
                for (int i = 0; i < AXES; i++)
                begin
                    origin_reg[i] <= origin_next[i];
                end
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign result   = res_reg;

`ifndef SYNTH
    a_calib_bound: assert property (@(posedge clk) disable iff (!rst_n)
        calib_cnt_reg <= CALIB_DONE)
        else $error("calibration count past done");

    a_zero_is_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase == PH_RUN) |=>
            !(res_reg.x_magnitude == '0 && !res_reg.x_negative) &&
            !(res_reg.y_magnitude == '0 && !res_reg.y_negative))
        else $error("zero deviation without negative flag");

    a_calib_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase != PH_RUN) |=>
            res_reg.direction == DIR_STOP && res_reg.x_magnitude == '0 &&
            res_reg.y_magnitude == '0 && res_reg.z_magnitude == '0)
        else $error("calibration result not cleared");

    a_origin_held: assert property (@(posedge clk) disable iff (!rst_n)
        (calib_cnt_reg == CALIB_DONE && $past(calib_cnt_reg == CALIB_DONE)) |->
            $stable(origin_reg[0]) && $stable(origin_reg[1]) && $stable(origin_reg[2]))
        else $error("origin changed while running");
`endif

endmodule

/* verif/accel_tilt_direction_detector_top_tb.sv */
`timescale 1ns / 100ps

module accel_tilt_direction_detector_top_tb;
    import atd_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 64;
    localparam int RUN_PHASES   = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int THR_RANDOM   = -1;

    typedef struct {
        item_t   smp;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    // tilt model state
    logic [THRESH_W-1:0] thr_model = THRESH_RESET;
    int                  calib_seen = 0;
    logic [ACCUM_W-1:0]  origin_sum [AXES] = '{default: '0};
    dev_t                axis_dev [AXES]   = '{default: '0};
    dir_t                held_dir = DIR_NONE;

    result_t   pending_readings [$];
    stim_row_t stim_rows [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_req      = 1'b0;
    int errors        = 0;
    int items_sent    = 0;
    int readings_seen = 0;
    int thr_writes    = 0;

    accel_tilt_direction_detector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic dev_t axis_offset(input logic [SAMPLE_W-1:0] s,
                                         input logic [ACCUM_W-1:0] o);
        dev_t r;
        int   diff;
        diff  = int'(s) - int'(o);
        r.neg = (diff <= 0);
        if (diff < 0)
        begin
            diff = -diff;
        end
        r.mag = (diff > 127) ? 7'h7F : 7'(diff);
        return r;
    endfunction

    function automatic dir_t steer(input dir_t cur, input dev_t d,
                                   input dir_t pos_code, input dir_t neg_code);
        dir_t r;
        r = cur;
        if (d.neg)
        begin
            r = (d.mag > thr_model) ? neg_code : DIR_STOP;
        end
        else if (d.mag == '0)
        begin
            r = DIR_STOP;
        end
        else if (d.mag > thr_model)
        begin
            r = pos_code;
        end
        return r;
    endfunction

    function automatic result_t predict_reading(input item_t it);
        result_t             r;
        phase_t              ph;
        logic [SAMPLE_W-1:0] smp [AXES];
        smp[0] = it.x_sample;
        smp[1] = it.y_sample;
        smp[2] = it.z_sample;
        if (calib_seen < 3)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                origin_sum[a] = origin_sum[a] + ACCUM_W'(smp[a]);
            end
            calib_seen++;
            ph = PH_CALIB;
        end
        else if (calib_seen == 3)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                origin_sum[a] = ACCUM_W'(origin_sum[a] / 3);
            end
            calib_seen++;
            ph = PH_ORIGIN;
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                axis_dev[a] = axis_offset(smp[a], origin_sum[a]);
            end
            ph = PH_RUN;
        end
        held_dir = steer(held_dir, axis_dev[0], DIR_LEFT, DIR_RIGHT);
        held_dir = steer(held_dir, axis_dev[1], DIR_FRONT, DIR_BACK);
        r = '0;
        r.phase = ph;
        if (ph == PH_RUN)
        begin
            r.x_magnitude = axis_dev[0].mag;
            r.x_negative  = axis_dev[0].neg;
            r.y_magnitude = axis_dev[1].mag;
            r.y_negative  = axis_dev[1].neg;
            r.z_magnitude = axis_dev[2].mag;
            r.z_negative  = axis_dev[2].neg;
        end
        r.direction = held_dir;
        return r;
    endfunction

    function automatic result_t mk_reading(input phase_t p,
                                           input logic [6:0] xm, input logic xn,
                                           input logic [6:0] ym, input logic yn,
                                           input logic [6:0] zm, input logic zn,
                                           input dir_t d);
        result_t r;
        r = '0;
        r.phase       = p;
        r.x_magnitude = xm;
        r.x_negative  = xn;
        r.y_magnitude = ym;
        r.y_negative  = yn;
        r.z_magnitude = zm;
        r.z_negative  = zn;
        r.direction   = d;
        return r;
    endfunction

    task automatic add_row(input int x, input int y, input int z,
                           input bit typed, input result_t want);
        stim_row_t row;
        row.smp.x_sample = 8'(x);
        row.smp.y_sample = 8'(y);
        row.smp.z_sample = 8'(z);
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // samples clustered round the origin reach the threshold boundaries
    function automatic logic [SAMPLE_W-1:0] random_axis(input int centre);
        int v;
        int span;
        span = int'(thr_model) + 3;
        case ($urandom_range(9))
            0, 1, 2, 3: v = centre - span + int'($urandom_range(2 * span));
            4:
            begin
                case ($urandom_range(2))
                    0:       v = 0;
                    1:       v = 255;
                    default: v = centre;
                endcase
            end
            default: v = int'($urandom_range(255));
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    task automatic push_item(input item_t it, input bit typed, input result_t want);
        result_t pred;
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pred = predict_reading(it);
        pending_readings.push_back(typed ? want : pred);
        items_sent++;
        if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
    endtask

    task automatic wait_drain();
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_model = v;
        thr_writes++;
    endtask

    task automatic field_cmp(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_reading(input result_t got);
        result_t want;
        if (pending_readings.size() == 0)
        begin
            $display("%0t: reading %h with nothing expected", $time, got);
            errors++;
        end
        else
        begin
            want = pending_readings.pop_front();
            field_cmp("phase", int'(want.phase), int'(got.phase));
            field_cmp("x_magnitude", int'(want.x_magnitude), int'(got.x_magnitude));
            field_cmp("x_negative", int'(want.x_negative), int'(got.x_negative));
            field_cmp("y_magnitude", int'(want.y_magnitude), int'(got.y_magnitude));
            field_cmp("y_negative", int'(want.y_negative), int'(got.y_negative));
            field_cmp("z_magnitude", int'(want.z_magnitude), int'(got.z_magnitude));
            field_cmp("z_negative", int'(want.z_negative), int'(got.z_negative));
            field_cmp("direction", int'(want.direction), int'(got.direction));
        end
    endtask

    // result side: check transfers, then choose next tready
    initial
    begin : reading_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                // tdata carries everything above the phase, which travels on tuser
                check_reading(result_t'({m_tdata[29:0], m_tuser}));
                readings_seen++;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int      thr_plan [RUN_PHASES];
        int      mode;
        item_t   it;
        result_t none;
        none = '0;
        thr_plan = '{0, 127, 10, THR_RANDOM, 1, 126, THR_RANDOM, THR_RANDOM};

        // calibration: origins come out at 128 on every axis, fourth triple ignored
        add_row(0, 255, 128, 1, mk_reading(PH_CALIB, 0, 0, 0, 0, 0, 0, DIR_STOP));
        add_row(255, 0, 128, 1, mk_reading(PH_CALIB, 0, 0, 0, 0, 0, 0, DIR_STOP));
        add_row(129, 129, 128, 1, mk_reading(PH_CALIB, 0, 0, 0, 0, 0, 0, DIR_STOP));
        add_row(255, 255, 255, 1, mk_reading(PH_ORIGIN, 0, 0, 0, 0, 0, 0, DIR_STOP));
        // equal to origin counts as negative
        add_row(128, 128, 128, 1, mk_reading(PH_RUN, 0, 1, 0, 1, 0, 1, DIR_STOP));
        add_row(255, 128, 0, 1, mk_reading(PH_RUN, 127, 0, 0, 1, 127, 1, DIR_STOP));
        add_row(0, 128, 255, 1, mk_reading(PH_RUN, 127, 1, 0, 1, 127, 0, DIR_STOP));
        add_row(255, 160, 128, 1, mk_reading(PH_RUN, 127, 0, 32, 0, 0, 1, DIR_FRONT));
        // small positive on both axes holds the code
        add_row(133, 133, 130, 1, mk_reading(PH_RUN, 5, 0, 5, 0, 2, 0, DIR_FRONT));
        add_row(128, 0, 128, 1, mk_reading(PH_RUN, 0, 1, 127, 1, 0, 1, DIR_BACK));
        add_row(139, 128, 1, 0, none);
        add_row(138, 139, 254, 0, none);
        add_row(118, 117, 127, 0, none);
        add_row(117, 148, 129, 0, none);
        add_row(1, 254, 128, 0, none);
        add_row(200, 60, 100, 0, none);
        add_row(128, 129, 128, 0, none);
        add_row(140, 138, 127, 0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            push_item(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].want);
        end
        s_tvalid <= 1'b0;
        wait_drain();

        for (int p = 0; p < RUN_PHASES; p++)
        begin
            mode = p % 4;
            snd_idle_pct  = (mode == 1) ? 87 : (mode == 3) ? 13 : 0;
            rcv_stall_pct = (mode == 2) ? 87 : (mode == 3) ? 13 : 0;
            if (thr_plan[p] == THR_RANDOM)
            begin
                write_threshold(7'($urandom_range(127)));
            end
            else
            begin
                write_threshold(7'(thr_plan[p]));
            end
            // long output hold-off while input keeps flowing, so the block backs up
            if (mode == 0)
            begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it.x_sample = random_axis(int'(origin_sum[0]));
                it.y_sample = random_axis(int'(origin_sum[1]));
                it.z_sample = random_axis(int'(origin_sum[2]));
                push_item(it, 1'b0, none);
            end
            s_tvalid <= 1'b0;
            wait_drain();
        end

        repeat (8) @(posedge clk);
        $display("Run covered %0d sample triples and %0d readings over %0d threshold writes,",
                 items_sent, readings_seen, thr_writes);
        $display("with calibration, saturation, threshold edges and four handshake modes.");
        if (errors == 0 && pending_readings.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d readings missing", errors, pending_readings.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* accel_tilt_direction_detector_top.f */
hw/rtl/atd_pkg.sv
hw/rtl/atd_in_stage.sv
hw/rtl/atd_core.sv
hw/rtl/accel_tilt_direction_detector_top.sv
verif/accel_tilt_direction_detector_top_tb.sv
